### sv/mbc3_pkg.sv
// Package: shared types and constants of the MBC3 memory map.
package mbc3_pkg;

  localparam int RomBytesDef = 131072;
  localparam int PosW        = 21;
  localparam int ClrW        = 15;
  localparam int OamDepth    = 160;
  localparam int HramDepth   = 127;

  localparam logic [15:0] AddrJoyp    = 16'hFF00;
  localparam logic [15:0] AddrIf      = 16'hFF0F;
  localparam logic [15:0] AddrIe      = 16'hFFFF;
  localparam logic [15:0] AddrDma     = 16'hFF46;
  localparam logic [15:0] AddrPpuLo   = 16'hFF40;
  localparam logic [15:0] AddrPpuHi   = 16'hFF4B;
  localparam logic [15:0] AddrOamLo   = 16'hFE00;
  localparam logic [15:0] AddrOamHi   = 16'hFE9F;
  localparam logic [15:0] AddrHramLo  = 16'hFF80;
  localparam logic [15:0] AddrHramHi  = 16'hFFFE;

  localparam logic [7:0] JoypBase  = 8'hCF;
  localparam logic [7:0] IfMask    = 8'hE0;
  localparam logic [7:0] JoypKeep  = 8'h30;
  localparam logic [7:0] IrqJoyp   = 8'h10;
  localparam logic [3:0] RamEnKey  = 4'hA;
  localparam logic [7:0] OpenBus   = 8'hFF;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_JOYPAD = 2'd2,
    KIND_LOAD   = 2'd3
  } kind_e;

  typedef struct packed {
    logic accept;
    logic dma_rd;
    logic dma_wr;
    logic clr_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_dma;
    logic dma_last;
    logic clr_last;
  } sts_t;

endpackage

### sv/mbc3_intf.sv
// Interfaces: request, response and configuration channels.
interface mbc3_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [7:0]  value;
  logic [16:0] rom_offset;
  logic [7:0]  buttons;
  modport source (output valid, kind, address, value, rom_offset, buttons, input ready);
  modport sink   (input valid, kind, address, value, rom_offset, buttons, output ready);
endinterface

interface mbc3_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       ppu_select;
  logic       ppu_write;
  logic [3:0] ppu_register;
  logic [7:0] ppu_write_data;
  modport source (output valid, read_data, ppu_select, ppu_write, ppu_register,
                  ppu_write_data, input ready);
  modport sink   (input valid, read_data, ppu_select, ppu_write, ppu_register,
                  ppu_write_data, output ready);
endinterface

interface mbc3_cfg_if;
  logic        valid;
  logic        ready;
  logic [17:0] rom_size;
  modport source (output valid, rom_size, input ready);
  modport sink   (input valid, rom_size, output ready);
endinterface

### sv/mbc3_ctrl.sv
// Controller: sequences clearing, item execution, DMA copy and result beats.
module mbc3_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  logic           rsp_ready_i,
  output logic           rsp_valid_o,
  input  mbc3_pkg::sts_t sts_i,
  output mbc3_pkg::cmd_t cmd_o
);
  import mbc3_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DMA_RD,
    ST_DMA_WR,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.dma_rd   = (state_q == ST_DMA_RD);
    cmd_o.dma_wr   = (state_q == ST_DMA_WR);
    cmd_o.clr_step = (state_q == ST_CLEAR);
    cmd_o.load_out = (state_q == ST_EXEC) && (!out_valid_q || rsp_ready_i);
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd_o.accept) state_q <= sts_i.is_dma ? ST_DMA_RD : ST_EXEC;
        end
        ST_DMA_RD: state_q <= ST_DMA_WR;
        ST_DMA_WR: begin
          state_q <= sts_i.dma_last ? ST_EXEC : ST_DMA_RD;
        end
        ST_EXEC: begin
          if (cmd_o.load_out) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### sv/mbc3_datapath.sv
// Datapath: bank registers, memories, read decode and result register.
module mbc3_datapath #(
  parameter int ROM_BYTES = mbc3_pkg::RomBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mbc3_pkg::cmd_t cmd_i,
  output mbc3_pkg::sts_t sts_o,
  input  logic [1:0]     kind_i,
  input  logic [15:0]    address_i,
  input  logic [7:0]     value_i,
  input  logic [16:0]    rom_offset_i,
  input  logic [7:0]     buttons_i,
  input  logic           cfg_valid_i,
  input  logic [17:0]    cfg_rom_size_i,
  output logic [7:0]     read_data_o,
  output logic           ppu_select_o,
  output logic           ppu_write_o,
  output logic [3:0]     ppu_register_o,
  output logic [7:0]     ppu_write_data_o
);
  import mbc3_pkg::*;

  localparam int          RomAw    = $clog2(ROM_BYTES);
  localparam logic [21:0] RomLimit = 22'(ROM_BYTES);

  typedef enum logic [2:0] {
    SRC_DIRECT,
    SRC_ROM,
    SRC_VRAM,
    SRC_CRAM,
    SRC_WRAM,
    SRC_OAM,
    SRC_HRAM
  } src_e;

  logic [6:0]  rom_bank_q;
  logic [1:0]  ram_bank_q;
  logic        cram_en_q;
  logic [7:0]  joy_sel_q, btn_q, if_q, ie_q;
  logic [17:0] rom_size_q;
  logic [ClrW-1:0] clr_cnt_q;
  logic [7:0]  dma_cnt_q;
  kind_e       kind_q;
  logic [15:0] addr_q;
  logic [7:0]  val_q;

  logic [7:0] rom_mem  [ROM_BYTES];
  logic [7:0] vram_mem [8192];
  logic [7:0] wram_mem [8192];
  logic [7:0] cram_mem [32768];
  logic [7:0] oam_mem  [OamDepth];
  logic [7:0] hram_mem [HramDepth];

  logic [7:0] rom_rd_q, vram_rd_q, wram_rd_q, cram_rd_q, oam_rd_q, hram_rd_q;
  src_e       src_q;
  logic [7:0] direct_q;

  kind_e       kind_in;
  logic        acc_wr;
  logic        rd_en;
  logic [15:0] rd_addr;
  src_e        src_d;
  logic [7:0]  direct_d;
  logic [7:0]  joy_byte;
  logic [PosW-1:0] rom_pos;
  logic        rom_ok;
  logic [7:0]  rd_byte;
  logic [7:0]  fell;
  logic        irq;
  logic        ppu_hit, ppu_fwd;

  assign kind_in = kind_e'(kind_i);
  assign acc_wr  = cmd_i.accept && (kind_in == KIND_WRITE);
  assign rd_en   = cmd_i.accept || cmd_i.dma_rd;
  assign rd_addr = cmd_i.dma_rd ? {val_q, dma_cnt_q} : address_i;

  assign sts_o.is_dma   = (kind_in == KIND_WRITE) && (address_i == AddrDma);
  assign sts_o.dma_last = (dma_cnt_q == 8'(OamDepth - 1));
  assign sts_o.clr_last = &clr_cnt_q;

  always_comb begin
    joy_byte = joy_sel_q | JoypBase;
    if (!joy_sel_q[4]) joy_byte = joy_byte & {4'hF, btn_q[7:4]};
    if (!joy_sel_q[5]) joy_byte = joy_byte & {4'hF, btn_q[3:0]};
  end

  assign rom_pos = (rd_addr[15:14] == 2'b00) ? {7'd0, rd_addr[13:0]}
                                             : {rom_bank_q, rd_addr[13:0]};
  assign rom_ok  = ({1'b0, rom_pos} < {4'd0, rom_size_q}) && ({1'b0, rom_pos} < RomLimit);

  always_comb begin
    src_d    = SRC_DIRECT;
    direct_d = OpenBus;
    if (rd_addr == AddrJoyp) begin
      direct_d = joy_byte;
    end else if (rd_addr == AddrIf) begin
      direct_d = if_q | IfMask;
    end else if (rd_addr == AddrIe) begin
      direct_d = ie_q;
    end else if (rd_addr >= AddrPpuLo && rd_addr <= AddrPpuHi) begin
      direct_d = OpenBus;
    end else if (rd_addr <= 16'h7FFF) begin
      if (rom_ok) src_d = SRC_ROM;
    end else if (rd_addr <= 16'h9FFF) begin
      src_d = SRC_VRAM;
    end else if (rd_addr <= 16'hBFFF) begin
      if (cram_en_q) src_d = SRC_CRAM;
    end else if (rd_addr <= 16'hDFFF) begin
      src_d = SRC_WRAM;
    end else if (rd_addr >= AddrHramLo && rd_addr <= AddrHramHi) begin
      src_d = SRC_HRAM;
    end else if (rd_addr >= AddrOamLo && rd_addr <= AddrOamHi) begin
      src_d = SRC_OAM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      src_q    <= src_d;
      direct_q <= direct_d;
    end
  end

  always_comb begin
    case (src_q)
      SRC_ROM:  rd_byte = rom_rd_q;
      SRC_VRAM: rd_byte = vram_rd_q;
      SRC_CRAM: rd_byte = cram_rd_q;
      SRC_WRAM: rd_byte = wram_rd_q;
      SRC_OAM:  rd_byte = oam_rd_q;
      SRC_HRAM: rd_byte = hram_rd_q;
      default:  rd_byte = direct_q;
    endcase
  end

  // ROM store
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && kind_in == KIND_LOAD && (22'(rom_offset_i) < RomLimit))
      rom_mem[RomAw'(rom_offset_i)] <= value_i;
    if (rd_en) rom_rd_q <= rom_mem[rom_pos[RomAw-1:0]];
  end

  // Video RAM
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      vram_mem[clr_cnt_q[12:0]] <= 8'h00;
    end else if (acc_wr && address_i[15:13] == 3'b100) begin
      vram_mem[address_i[12:0]] <= value_i;
    end
    if (rd_en) vram_rd_q <= vram_mem[rd_addr[12:0]];
  end

  // Work RAM
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      wram_mem[clr_cnt_q[12:0]] <= 8'h00;
    end else if (acc_wr && address_i[15:13] == 3'b110) begin
      wram_mem[address_i[12:0]] <= value_i;
    end
    if (rd_en) wram_rd_q <= wram_mem[rd_addr[12:0]];
  end

  // Cartridge RAM
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      cram_mem[clr_cnt_q] <= 8'h00;
    end else if (acc_wr && cram_en_q && address_i[15:13] == 3'b101) begin
      cram_mem[{ram_bank_q, address_i[12:0]}] <= value_i;
    end
    if (rd_en) cram_rd_q <= cram_mem[{ram_bank_q, rd_addr[12:0]}];
  end

  // Sprite attribute memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      if (clr_cnt_q < ClrW'(OamDepth)) oam_mem[clr_cnt_q[7:0]] <= 8'h00;
    end else if (cmd_i.dma_wr) begin
      oam_mem[dma_cnt_q] <= rd_byte;
    end else if (acc_wr && address_i >= AddrOamLo && address_i <= AddrOamHi) begin
      oam_mem[address_i[7:0]] <= value_i;
    end
    if (rd_en) oam_rd_q <= oam_mem[rd_addr[7:0]];
  end

  // High RAM
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      if (clr_cnt_q < ClrW'(HramDepth)) hram_mem[clr_cnt_q[6:0]] <= 8'h00;
    end else if (acc_wr && address_i >= AddrHramLo && address_i <= AddrHramHi) begin
      hram_mem[address_i[6:0]] <= value_i;
    end
    if (rd_en) hram_rd_q <= hram_mem[rd_addr[6:0]];
  end

  assign fell = btn_q & ~buttons_i;
  assign irq  = (!joy_sel_q[4] && (fell[7:4] != 4'h0)) ||
                (!joy_sel_q[5] && (fell[3:0] != 4'h0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q <= 7'd1;
      ram_bank_q <= 2'd0;
      cram_en_q  <= 1'b0;
      joy_sel_q  <= 8'h00;
      btn_q      <= 8'hFF;
      if_q       <= 8'h00;
      ie_q       <= 8'h00;
      rom_size_q <= '0;
      clr_cnt_q  <= '0;
      dma_cnt_q  <= '0;
    end else begin
      if (cfg_valid_i) rom_size_q <= cfg_rom_size_i;
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.accept) begin
        dma_cnt_q <= '0;
      end else if (cmd_i.dma_wr) begin
        dma_cnt_q <= dma_cnt_q + 1'b1;
      end
      if (cmd_i.accept && kind_in == KIND_JOYPAD) begin
        btn_q <= buttons_i;
        if (irq) if_q <= if_q | IrqJoyp;
      end
      if (acc_wr) begin
        if (address_i == AddrJoyp) begin
          joy_sel_q <= value_i & JoypKeep;
        end else if (address_i == AddrIf) begin
          if_q <= value_i;
        end else if (address_i == AddrIe) begin
          ie_q <= value_i;
        end else if (address_i >= AddrPpuLo && address_i <= AddrPpuHi) begin
          cram_en_q <= cram_en_q;
        end else if (address_i <= 16'h1FFF) begin
          cram_en_q <= (value_i[3:0] == RamEnKey);
        end else if (address_i <= 16'h3FFF) begin
          rom_bank_q <= (value_i[6:0] == 7'd0) ? 7'd1 : value_i[6:0];
        end else if (address_i <= 16'h5FFF) begin
          if (value_i <= 8'd3) ram_bank_q <= value_i[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_in;
      addr_q <= address_i;
      val_q  <= value_i;
    end
  end

  assign ppu_hit = (addr_q >= AddrPpuLo) && (addr_q <= AddrPpuHi);
  assign ppu_fwd = (kind_q == KIND_WRITE) && ppu_hit && (addr_q != AddrDma);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_data_o      <= (kind_q == KIND_READ) ? rd_byte : OpenBus;
      ppu_select_o     <= ((kind_q == KIND_READ) && ppu_hit) || ppu_fwd;
      ppu_write_o      <= ppu_fwd;
      ppu_register_o   <= (((kind_q == KIND_READ) && ppu_hit) || ppu_fwd) ? addr_q[3:0] : 4'd0;
      ppu_write_data_o <= ppu_fwd ? val_q : 8'h00;
    end
  end

endmodule

### sv/banked_memory_map_with_mbc3_unit.sv
// Top level: MBC3 banked memory map, controller plus datapath.
// After reset the block clears its RAMs and takes no request beat until
// then (configuration beats are taken at any time). A bus read, bus
// write, joypad update or ROM load first issues the registered memory
// read on accept and then, once the result register is free to take it,
// loads the result register. A write to 0xFF46 copies 160 bytes through
// the single read port, a read state and an OAM write state per byte. The
// next request is taken while a finished result beat still waits.
module banked_memory_map_with_mbc3_unit #(
  parameter int ROM_BYTES = mbc3_pkg::RomBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbc3_req_if.sink   req_i,
  mbc3_rsp_if.source rsp_o,
  mbc3_cfg_if.sink   cfg_i
);
  import mbc3_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  mbc3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbc3_datapath #(
    .ROM_BYTES (ROM_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .kind_i           (req_i.kind),
    .address_i        (req_i.address),
    .value_i          (req_i.value),
    .rom_offset_i     (req_i.rom_offset),
    .buttons_i        (req_i.buttons),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_rom_size_i   (cfg_i.rom_size),
    .read_data_o      (rsp_o.read_data),
    .ppu_select_o     (rsp_o.ppu_select),
    .ppu_write_o      (rsp_o.ppu_write),
    .ppu_register_o   (rsp_o.ppu_register),
    .ppu_write_data_o (rsp_o.ppu_write_data)
  );

`ifndef ASSERT_OFF
  a_no_req_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !req_i.ready) else $error("request taken during clear");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready) else $error("accept not followed by busy");

  a_load_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> rsp_o.valid) else $error("result load lost");
`endif

endmodule

### test/banked_memory_map_with_mbc3_unit_chk.sv
// Checker: watches the channels, predicts each response and compares it.
`timescale 1ns / 100ps
module banked_memory_map_with_mbc3_unit_chk (
  input  logic clk_i,
  input  logic rst_ni,
  mbc3_req_if  req,
  mbc3_rsp_if  rsp,
  mbc3_cfg_if  cfg,
  output int   errors,
  output int   pending
);
  import mbc3_pkg::*;

  typedef struct {
    logic [7:0] rd;
    logic       sel;
    logic       wr;
    logic [3:0] preg;
    logic [7:0] wd;
  } map_rsp_t;

  map_rsp_t   rsp_q[$];
  logic [7:0] rom_m[RomBytesDef];
  logic [7:0] vram_m[8192];
  logic [7:0] wram_m[8192];
  logic [7:0] cram_m[32768];
  logic [7:0] oam_m[OamDepth];
  logic [7:0] hram_m[HramDepth];
  logic [6:0] bank_r;
  logic [1:0] rbank_r;
  logic       cram_en;
  logic [7:0] joy_sel;
  logic [7:0] btn_r;
  logic [7:0] if_r;
  logic [7:0] ie_r;
  logic [17:0] rom_sz;

  assign pending = rsp_q.size();

  function automatic logic [7:0] rom_rd(int unsigned pos);
    if (pos >= rom_sz || pos >= RomBytesDef) return OpenBus;
    return rom_m[pos[16:0]];
  endfunction

  function automatic logic [7:0] map_rd(logic [15:0] a);
    logic [7:0] v;
    if (a == AddrJoyp) begin
      v = joy_sel | JoypBase;
      if (!joy_sel[4]) v &= {4'hF, btn_r[7:4]};
      if (!joy_sel[5]) v &= {4'hF, btn_r[3:0]};
      return v;
    end
    if (a == AddrIf) return if_r | IfMask;
    if (a == AddrIe) return ie_r;
    if (a >= AddrPpuLo && a <= AddrPpuHi) return OpenBus;
    if (a <= 16'h3FFF) return rom_rd(32'(a));
    if (a <= 16'h7FFF) return rom_rd(bank_r * 32'h4000 + (a - 16'h4000));
    if (a <= 16'h9FFF) return vram_m[a[12:0]];
    if (a <= 16'hBFFF) begin
      if (!cram_en) return OpenBus;
      return cram_m[{rbank_r, a[12:0]}];
    end
    if (a <= 16'hDFFF) return wram_m[a[12:0]];
    if (a >= AddrHramLo && a <= AddrHramHi) return hram_m[a[6:0]];
    if (a >= AddrOamLo && a <= AddrOamHi) return oam_m[a[7:0]];
    return OpenBus;
  endfunction

  function automatic void map_wr(logic [15:0] a, logic [7:0] v);
    logic [15:0] src;
    if (a == AddrJoyp) joy_sel = v & JoypKeep;
    else if (a == AddrIf) if_r = v;
    else if (a == AddrIe) ie_r = v;
    else if (a == AddrDma) begin
      for (int i = 0; i < OamDepth; i++) begin
        src = {v, 8'h00} + i[15:0];
        oam_m[i[7:0]] = map_rd(src);
      end
    end
    else if (a >= AddrPpuLo && a <= AddrPpuHi) ;
    else if (a <= 16'h1FFF) cram_en = (v[3:0] == RamEnKey);
    else if (a <= 16'h3FFF) bank_r = (v[6:0] == 0) ? 7'd1 : v[6:0];
    else if (a <= 16'h5FFF) begin
      if (v <= 3) rbank_r = v[1:0];
    end
    else if (a <= 16'h7FFF) ;
    else if (a <= 16'h9FFF) vram_m[a[12:0]] = v;
    else if (a <= 16'hBFFF) begin
      if (cram_en) cram_m[{rbank_r, a[12:0]}] = v;
    end
    else if (a <= 16'hDFFF) wram_m[a[12:0]] = v;
    else if (a >= AddrHramLo && a <= AddrHramHi) hram_m[a[6:0]] = v;
    else if (a >= AddrOamLo && a <= AddrOamHi) oam_m[a[7:0]] = v;
  endfunction

  function automatic map_rsp_t predict_beat(logic [1:0] k, logic [15:0] a, logic [7:0] v,
                                            logic [16:0] off, logic [7:0] btn);
    map_rsp_t e;
    logic     ppu;
    logic [7:0] fell;
    e = '{rd: OpenBus, sel: 1'b0, wr: 1'b0, preg: 4'h0, wd: 8'h00};
    ppu = (a >= AddrPpuLo && a <= AddrPpuHi);
    case (kind_e'(k))
      KIND_READ: begin
        e.rd = map_rd(a);
        if (ppu) begin
          e.sel = 1'b1;
          e.preg = a[3:0] - AddrPpuLo[3:0];
        end
      end
      KIND_WRITE: begin
        if (ppu && a != AddrDma) begin
          e.sel = 1'b1;
          e.wr = 1'b1;
          e.preg = a[3:0] - AddrPpuLo[3:0];
          e.wd = v;
        end
        map_wr(a, v);
      end
      KIND_JOYPAD: begin
        fell = btn_r & ~btn;
        if ((!joy_sel[4] && fell[7:4] != 0) || (!joy_sel[5] && fell[3:0] != 0))
          if_r |= IrqJoyp;
        btn_r = btn;
      end
      default: begin
        if (off < RomBytesDef) rom_m[off] = v;
      end
    endcase
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    map_rsp_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 8192; i++) begin
        vram_m[i[12:0]] = 8'h00;
        wram_m[i[12:0]] = 8'h00;
      end
      for (int i = 0; i < 32768; i++) cram_m[i[14:0]] = 8'h00;
      for (int i = 0; i < OamDepth; i++) oam_m[i[7:0]] = 8'h00;
      for (int i = 0; i < HramDepth; i++) hram_m[i[6:0]] = 8'h00;
      bank_r = 7'd1;
      rbank_r = 2'd0;
      cram_en = 1'b0;
      joy_sel = 8'h00;
      btn_r = 8'hFF;
      if_r = 8'h00;
      ie_r = 8'h00;
      rom_sz = '0;
      errors = 0;
      rsp_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response beat rd=%h", rsp.read_data);
        end else begin
          e = rsp_q.pop_front();
          if (rsp.read_data !== e.rd || rsp.ppu_select !== e.sel ||
              rsp.ppu_write !== e.wr || rsp.ppu_register !== e.preg ||
              rsp.ppu_write_data !== e.wd) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp rd=%h sel=%b wr=%b reg=%h wd=%h got %h %b %b %h %h",
                       e.rd, e.sel, e.wr, e.preg, e.wd, rsp.read_data, rsp.ppu_select,
                       rsp.ppu_write, rsp.ppu_register, rsp.ppu_write_data);
          end
        end
      end
      if (cfg.valid && cfg.ready) rom_sz = cfg.rom_size;
      if (req.valid && req.ready)
        rsp_q.push_back(predict_beat(req.kind, req.address, req.value,
                                     req.rom_offset, req.buttons));
    end
  end

endmodule

### test/banked_memory_map_with_mbc3_unit_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the MBC3 memory map.
`timescale 1ns / 100ps
module banked_memory_map_with_mbc3_unit_tb;
  import mbc3_pkg::*;

  localparam int WdogLimit = 100000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   send_pct = 0;
  int   stall_pct = 0;
  int   quiet = 0;

  logic        loaded[RomBytesDef];
  logic [6:0]  bank_sh = 7'd1;
  logic [17:0] size_sh = '0;

  mbc3_req_if req();
  mbc3_rsp_if rsp();
  mbc3_cfg_if cfg();

  banked_memory_map_with_mbc3_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  banked_memory_map_with_mbc3_unit_chk chk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg),
    .errors (errors),
    .pending(pending)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    req.valid = 1'b0;
    req.kind = 2'd0;
    req.address = '0;
    req.value = '0;
    req.rom_offset = '0;
    req.buttons = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.rom_size = '0;
    for (int i = 0; i < RomBytesDef; i++) loaded[i[16:0]] = 1'b0;
  end

  always @(posedge clk_i) rsp.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic rom_ok(int unsigned pos);
    return pos >= size_sh || pos >= RomBytesDef || loaded[pos[16:0]];
  endfunction

  function automatic int unsigned rom_pos(logic [15:0] a);
    if (a <= 16'h3FFF) return 32'(a);
    return bank_sh * 32'h4000 + (a - 16'h4000);
  endfunction

  task automatic send(logic [1:0] k, logic [15:0] a, logic [7:0] v,
                      logic [16:0] off, logic [7:0] btn);
    int n;
    logic ok;
    n = 0;
    if (k == KIND_READ && a <= 16'h7FFF && !rom_ok(rom_pos(a))) a = 16'h8000 | a[12:0];
    if (k == KIND_WRITE && a == AddrDma && v <= 8'h7F) begin
      ok = 1'b1;
      for (int i = 0; i < OamDepth; i++)
        if (!rom_ok(rom_pos({v, 8'h00} + i[15:0]))) ok = 1'b0;
      if (!ok) v = 8'hC0 | v[4:0];
    end
    if (k == KIND_WRITE && a >= 16'h2000 && a <= 16'h3FFF)
      bank_sh = (v[6:0] == 0) ? 7'd1 : v[6:0];
    if (k == KIND_LOAD) loaded[off] = 1'b1;
    while ($urandom_range(99) < send_pct) n++;
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.kind <= k;
    req.address <= a;
    req.value <= v;
    req.rom_offset <= off;
    req.buttons <= btn;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic set_size(logic [17:0] s);
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    cfg.valid <= 1'b1;
    cfg.rom_size <= s;
    size_sh = s;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_addr();
    logic [15:0] w;
    w = 16'($urandom_range(63));
    case ($urandom_range(11))
      0: return w;
      1: return 16'h4000 | w;
      2: return 16'h8000 | w;
      3, 4: return 16'hA000 | w;
      5: return 16'hC000 | w;
      6: return AddrOamLo | w;
      7: return 16'(AddrHramLo + $urandom_range(126));
      8: begin
        case ($urandom_range(3))
          0: return AddrJoyp;
          1: return AddrIf;
          2: return AddrIe;
          default: return 16'(AddrPpuLo + $urandom_range(11));
        endcase
      end
      9: return 16'($urandom_range(16'h7FFF));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic rand_item();
    logic [15:0] a;
    logic [7:0]  v;
    logic [16:0] off;
    int r;
    a = pick_addr();
    v = 8'($urandom_range(255));
    r = $urandom_range(99);
    if ($urandom_range(3) == 0) off = 17'($urandom_range(RomBytesDef - 1));
    else off = 17'($urandom_range(7) * 32'h4000 + $urandom_range(511));
    if (r < 35) send(KIND_READ, a, v, off, v);
    else if (r < 70) begin
      case ($urandom_range(19))
        0: a = 16'($urandom_range(16'h1FFF));
        1: a = 16'(16'h2000 | $urandom_range(16'h1FFF));
        2: a = 16'(16'h4000 | $urandom_range(16'h1FFF));
        3: begin
          a = 16'h0000;
          v = {v[7:4], RamEnKey};
        end
        default: if ($urandom_range(99) == 0) a = AddrDma;
      endcase
      if (a >= 16'h4000 && a <= 16'h5FFF && v[7]) v = v & 8'h03;
      send(KIND_WRITE, a, v, off, v);
    end
    else if (r < 80) send(KIND_JOYPAD, a, v, off, 8'($urandom_range(255)));
    else send(KIND_LOAD, a, v, off, v);
  endtask

  initial begin
    logic [17:0] sizes[5];
    int sp[5];
    int rp[5];
    sizes = '{18'd131072, 18'd512, 18'd20000, 18'd0, 18'd131072};
    sp = '{0, 86, 0, 36, 0};
    rp = '{0, 0, 86, 36, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_size(18'd0);
    send(KIND_LOAD, 16'h0000, 8'hA5, 17'd0, 8'h00);
    send(KIND_LOAD, 16'hFFFF, 8'h5A, 17'h1FFFF, 8'hFF);
    send(KIND_READ, 16'h0000, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, 16'h0000, 8'h0A, 17'd0, 8'h00);
    send(KIND_WRITE, 16'hA000, 8'h11, 17'd0, 8'h00);
    send(KIND_READ, 16'hA000, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, 16'h4000, 8'h03, 17'd0, 8'h00);
    send(KIND_WRITE, 16'h5FFF, 8'h04, 17'd0, 8'h00);
    send(KIND_WRITE, 16'hBFFF, 8'hFF, 17'd0, 8'h00);
    send(KIND_READ, 16'hBFFF, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, 16'h2000, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, 16'h3FFF, 8'hFF, 17'd0, 8'h00);
    send(KIND_READ, 16'h7FFF, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, AddrJoyp, 8'hFF, 17'd0, 8'h00);
    send(KIND_READ, AddrJoyp, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, AddrJoyp, 8'h00, 17'd0, 8'h00);
    send(KIND_JOYPAD, 16'h0000, 8'h00, 17'd0, 8'h00);
    send(KIND_READ, AddrIf, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, AddrIe, 8'hFF, 17'd0, 8'h00);
    send(KIND_READ, AddrIe, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, AddrPpuLo, 8'h91, 17'd0, 8'h00);
    send(KIND_READ, AddrPpuHi, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, AddrDma, 8'hA0, 17'd0, 8'h00);
    send(KIND_READ, AddrOamHi, 8'h00, 17'd0, 8'h00);
    send(KIND_READ, 16'hE000, 8'h00, 17'd0, 8'h00);
    send(KIND_READ, 16'hFEA0, 8'h00, 17'd0, 8'h00);
    send(KIND_WRITE, 16'h1FFF, 8'h00, 17'd0, 8'h00);
    for (int p = 0; p < 5; p++) begin
      set_size(sizes[p]);
      send_pct = sp[p];
      stall_pct = rp[p];
      repeat (140) rand_item();
    end
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/mbc3_pkg.sv
sv/mbc3_intf.sv
sv/mbc3_ctrl.sv
sv/mbc3_datapath.sv
sv/banked_memory_map_with_mbc3_unit.sv
test/banked_memory_map_with_mbc3_unit_chk.sv
test/banked_memory_map_with_mbc3_unit_tb.sv
